// ===== hw/rtl/wgm_pkg.sv =====
// Shared types and constants for the wildcard glob matcher.
// No dependencies; used by wgm_nfa and wildcard_glob_matcher.
package wgm_pkg;

	localparam int MAX_PATTERN_DEF = 32;
	localparam int SYM_W = 8;

	localparam logic [SYM_W-1:0] SYM_STAR = 8'h2A;
	localparam logic [SYM_W-1:0] SYM_ANY  = 8'h3F;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_TEXT   = 2'd2,
		CMD_END    = 2'd3
	} cmd_t;

	// one word handed to the matcher core in the cycle it is processed
	typedef struct packed {
		logic             en;
		cmd_t             cmd;
		logic [SYM_W-1:0] sym;
	} op_t;

	typedef struct packed {
		logic matched;
		logic overflow;
	} res_t;

endpackage

// ===== hw/rtl/wgm_nfa.sv =====
// Pattern store and bit-parallel live-position set of the glob matcher.
// Depends on wgm_pkg.
module wgm_nfa #(
	parameter int MAX_PATTERN = wgm_pkg::MAX_PATTERN_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  wgm_pkg::op_t  op,
	output wgm_pkg::res_t res
);

	localparam int W = MAX_PATTERN + 1;

	logic [wgm_pkg::SYM_W-1:0] pat_q [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] act_q;
	logic [MAX_PATTERN-1:0] star_q;
	logic [MAX_PATTERN-1:0] any_q;
	logic [W-1:0]           live_q;
	logic                   ovf_q;

	logic [MAX_PATTERN-1:0] slot;
	logic [MAX_PATTERN-1:0] hit;
	logic [MAX_PATTERN-1:0] star_act;
	logic [W-1:0]           prop;
	logic [W-1:0]           closed;
	logic [W-1:0]           nxt;
	logic [W-1:0]           end_mask;
	logic                   full;

	// slot is the first unused entry, one-hot
	assign slot = ~act_q & ((act_q << 1) | MAX_PATTERN'(1));

	assign full     = act_q[MAX_PATTERN-1];
	assign star_act = act_q & star_q;

	// star closure as a carry chain: a live bit inside a run of stars
	// ripples through the run and one position past it
	assign prop   = {1'b0, star_act};
	assign closed = live_q | (((live_q & prop) + prop) ^ prop);

	always_comb begin
		for (int i = 0; i < MAX_PATTERN; i++) begin
			hit[i] = act_q[i] && !star_q[i] && (any_q[i] || (pat_q[i] == op.sym));
		end
	end

	assign nxt      = {closed[MAX_PATTERN-1:0] & hit, 1'b0}
	                | {1'b0, closed[MAX_PATTERN-1:0] & star_act};
	assign end_mask = {act_q, 1'b1} & ~{1'b0, act_q};

	assign res.matched  = |(closed & end_mask);
	assign res.overflow = ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= '0;
			ovf_q  <= 1'b0;
			live_q <= W'(1);
		end else if (op.en) begin
			case (op.cmd)
				wgm_pkg::CMD_CLEAR: begin
					act_q  <= '0;
					ovf_q  <= 1'b0;
					live_q <= W'(1);
				end
				wgm_pkg::CMD_APPEND: begin
					if (full) begin
						ovf_q <= 1'b1;
					end else begin
						act_q <= act_q | slot;
					end
					live_q <= W'(1);
				end
				wgm_pkg::CMD_TEXT: begin
					live_q <= nxt;
				end
				wgm_pkg::CMD_END: begin
					live_q <= W'(1);
				end
				default: begin
					live_q <= live_q;
				end
			endcase
		end
	end

	// pattern entries hold no reset; only entries marked active are used
	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_PATTERN; i++) begin
			if (op.en && op.cmd == wgm_pkg::CMD_APPEND && slot[i]) begin
				pat_q[i]  <= op.sym;
				star_q[i] <= (op.sym == wgm_pkg::SYM_STAR);
				any_q[i]  <= (op.sym == wgm_pkg::SYM_ANY);
			end
		end
	end

endmodule

// ===== hw/rtl/wildcard_glob_matcher.sv =====
// Top level of the streaming glob matcher: input register, core, result register.
// Depends on wgm_pkg and wgm_nfa.
//
// Streaming glob matcher. Clear the pattern, append its bytes one word at a
// time ('*' matches any run, '?' any one byte), then send text bytes and an
// end-of-text word; the end-of-text word returns one result with matched and
// the sticky pattern_overflow flag. Appends beyond MAX_PATTERN are dropped and
// set the flag until the next clear; clear and append also restart a text.
// The block takes one word every cycle; a result is offered from the result
// register once its end-of-text word has passed the input register and the core,
// and an end-of-text word waits only while an unread result still holds the result
// register. That rate is set by the live-position update, one star-closure carry
// chain and one byte compare per pattern entry, which updates the live set for a
// text byte combinationally. No clearing pass follows reset.
module wildcard_glob_matcher #(
	parameter int MAX_PATTERN = wgm_pkg::MAX_PATTERN_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [1:0]                command,
	input  logic [wgm_pkg::SYM_W-1:0] symbol,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      matched,
	output logic                      pattern_overflow
);

	logic                      vld_s1;
	wgm_pkg::cmd_t             cmd_s1;
	logic [wgm_pkg::SYM_W-1:0] sym_s1;
	logic                      out_vld_q;
	wgm_pkg::res_t             res_q;
	wgm_pkg::res_t             res;
	wgm_pkg::op_t              op;
	logic                      adv;

	// an end-of-text word waits only while the result register is still full
	assign adv = vld_s1 && (cmd_s1 != wgm_pkg::CMD_END || !out_vld_q || out_ready);
	assign in_ready = !vld_s1 || adv;

	assign op.en  = adv;
	assign op.cmd = cmd_s1;
	assign op.sym = sym_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1 <= wgm_pkg::cmd_t'(command);
			sym_s1 <= symbol;
		end
	end

	wgm_nfa #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_nfa (
		.clk   (clk),
		.arst_n(arst_n),
		.op    (op),
		.res   (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv && cmd_s1 == wgm_pkg::CMD_END) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && cmd_s1 == wgm_pkg::CMD_END) begin
			res_q <= res;
		end
	end

	assign out_valid        = out_vld_q;
	assign matched          = res_q.matched;
	assign pattern_overflow = res_q.overflow;

endmodule

// ===== tb/wildcard_glob_matcher_tb.sv =====
// Testbench for wildcard_glob_matcher: directed and random command streams.
// Each result is checked against a position-by-position glob predictor kept in this file.
// Depends on wgm_pkg and the wildcard_glob_matcher RTL.
module wildcard_glob_matcher_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import wgm_pkg::*;

	localparam int PAT_CAP = MAX_PATTERN_DEF;
	localparam logic [PAT_CAP:0] LIVE_START = (PAT_CAP+1)'(1);
	localparam int TARGET_WORDS = 975;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 10;
	localparam int LONG_HOLD = 400;

	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] sym;
		logic       drain;
	} word_t;

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_RHYTHM} rx_mode_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	cmd_t       command = CMD_CLEAR;
	logic [7:0] symbol = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       matched;
	logic       pattern_overflow;

	wildcard_glob_matcher #(
		.MAX_PATTERN(PAT_CAP)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.symbol(symbol),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.matched(matched),
		.pattern_overflow(pattern_overflow)
	);

	always #2 clk = ~clk;

	// glob predictor state
	logic [7:0]     pat_mem [PAT_CAP];
	int             pat_len;
	logic [PAT_CAP:0] live;
	logic           ovf_sticky;
	res_t           results_due [$];

	word_t pending [$];
	word_t next_word;
	int    errors = 0;
	int    cycles = 0;

	function void close_stars();
		for (int i = 0; i < pat_len; i++)
			if (live[i] && pat_mem[i] == SYM_STAR)
				live[i+1] = 1'b1;
	endfunction

	function void glob_step(cmd_t cmd, logic [7:0] sym);
		logic [PAT_CAP:0] nxt;
		res_t r;
		case (cmd)
			CMD_CLEAR: begin
				pat_len = 0;
				ovf_sticky = 1'b0;
				live = LIVE_START;
			end
			CMD_APPEND: begin
				if (pat_len < PAT_CAP) begin
					pat_mem[pat_len] = sym;
					pat_len++;
				end else
					ovf_sticky = 1'b1;
				live = LIVE_START;
			end
			CMD_TEXT: begin
				close_stars();
				nxt = '0;
				for (int i = 0; i < pat_len; i++) begin
					if (live[i]) begin
						if (pat_mem[i] == SYM_STAR)
							nxt[i] = 1'b1;
						else if (pat_mem[i] == SYM_ANY || pat_mem[i] == sym)
							nxt[i+1] = 1'b1;
					end
				end
				live = nxt;
			end
			default: begin
				close_stars();
				r.matched = live[pat_len];
				r.overflow = ovf_sticky;
				results_due.push_back(r);
				live = LIVE_START;
			end
		endcase
	endfunction

	function void put(cmd_t c, logic [7:0] s);
		word_t w;
		w.cmd = c;
		w.sym = s;
		w.drain = 1'b0;
		pending.push_back(w);
	endfunction

	// mostly a small alphabet so that matches are common
	function automatic logic [7:0] pick_sym(bit for_pattern);
		case ($urandom_range(0, 9))
			0, 1: return for_pattern ? SYM_STAR : 8'h61;
			2: return for_pattern ? SYM_ANY : 8'h62;
			3: return 8'($urandom_range(0, 255));
			default: return 8'h61 + 8'($urandom_range(0, 2));
		endcase
	endfunction

	// sender: bursts of random length, random gaps between them
	int burst_left, gap_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			command <= CMD_CLEAR;
			symbol <= 8'h00;
			burst_left = 0;
			gap_left = 0;
			pat_len = 0;
			ovf_sticky = 1'b0;
			live = LIVE_START;
		end else begin
			if (in_valid && in_ready)
				glob_step(command, symbol);
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending.size() != 0 && pending[0].drain) begin
					// hold until every result is back
					if (results_due.size() == 0)
						next_word = pending.pop_front();
					in_valid <= 1'b0;
				end else if (pending.size() != 0) begin
					next_word = pending.pop_front();
					command <= next_word.cmd;
					symbol <= next_word.sym;
					in_valid <= 1'b1;
					if (burst_left > 1)
						burst_left--;
					else begin
						burst_left = $urandom_range(1, 48);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// receiver and checker
	int       hold_left, phase_left, results_seen;
	bit       long_hold_done;
	rx_mode_t rx_mode;
	res_t     want;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left = 0;
			phase_left = 0;
			results_seen = 0;
			long_hold_done = 1'b0;
			rx_mode = RX_OPEN;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (results_due.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result word: matched=%0b overflow=%0b",
							matched, pattern_overflow);
				end else begin
					want = results_due.pop_front();
					if (matched !== want.matched || pattern_overflow !== want.overflow) begin
						errors++;
						if (errors <= 10)
							$display("result %0d: matched exp %0b got %0b, overflow exp %0b got %0b",
								results_seen, want.matched, matched,
								want.overflow, pattern_overflow);
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (!long_hold_done && results_seen >= 30) begin
				// long hold-off so the block fills and stalls its input
				long_hold_done = 1'b1;
				hold_left = LONG_HOLD - 1;
				out_ready <= 1'b0;
			end else begin
				if (phase_left == 0) begin
					rx_mode = rx_mode_t'(2'($urandom_range(0, 3)));
					phase_left = $urandom_range(16, 96);
				end else
					phase_left--;
				case (rx_mode)
					RX_OPEN: out_ready <= 1'b1;
					RX_COIN: out_ready <= 1'($urandom_range(0, 1));
					RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
					default: out_ready <= (phase_left % 5 < 3);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		logic [7:0] gen_pat [$];
		logic [7:0] b;
		word_t      pw;
		int         plen, seq;

		// empty pattern: empty text matches, any other text does not
		put(CMD_END, 8'hFF);
		put(CMD_TEXT, 8'h00);
		put(CMD_END, 8'h00);
		// lone star takes the empty text and any run
		put(CMD_APPEND, SYM_STAR);
		put(CMD_END, 8'h00);
		put(CMD_TEXT, 8'h78);
		put(CMD_TEXT, 8'h79);
		put(CMD_END, 8'hAA);
		// byte zero and 0xFF as literals around a one-byte wildcard
		put(CMD_CLEAR, 8'hFF);
		put(CMD_APPEND, 8'h00);
		put(CMD_APPEND, SYM_ANY);
		put(CMD_APPEND, 8'hFF);
		put(CMD_TEXT, 8'h00);
		put(CMD_TEXT, 8'h80);
		put(CMD_TEXT, 8'hFF);
		put(CMD_END, 8'h55);
		// an append in mid-text restarts tracking
		put(CMD_TEXT, 8'h00);
		put(CMD_APPEND, 8'h01);
		put(CMD_TEXT, 8'h00);
		put(CMD_TEXT, SYM_STAR);
		put(CMD_TEXT, 8'hFF);
		put(CMD_TEXT, 8'h01);
		put(CMD_END, 8'h00);
		// text 00 FF skips the '?' byte and the trailing 01, so it does not match
		put(CMD_TEXT, 8'h00);
		put(CMD_TEXT, 8'hFF);
		put(CMD_END, 8'h00);

		seq = 0;
		while (pending.size() < TARGET_WORDS) begin
			if ($urandom_range(0, 9) < 8) begin
				if (seq == 0 || $urandom_range(0, 7) != 0) begin
					put(CMD_CLEAR, 8'($urandom_range(0, 255)));
					gen_pat.delete();
				end
				case ($urandom_range(0, 15))
					0: plen = $urandom_range(28, 40);
					1, 2: plen = $urandom_range(9, 27);
					default: plen = $urandom_range(0, 8);
				endcase
				// first pattern runs past capacity
				if (seq == 0)
					plen = PAT_CAP + 4;
				for (int k = 0; k < plen; k++) begin
					b = pick_sym(1'b1);
					put(CMD_APPEND, b);
					if (gen_pat.size() < PAT_CAP)
						gen_pat.push_back(b);
				end
				repeat ($urandom_range(1, 4)) begin
					if ($urandom_range(0, 2) != 0) begin
						// text built to match, with an occasional spoiled byte
						for (int j = 0; j < gen_pat.size(); j++) begin
							if (gen_pat[j] == SYM_STAR)
								repeat ($urandom_range(0, 3)) put(CMD_TEXT, pick_sym(1'b0));
							else if (gen_pat[j] == SYM_ANY)
								put(CMD_TEXT, 8'($urandom_range(0, 255)));
							else if ($urandom_range(0, 11) == 0)
								put(CMD_TEXT, pick_sym(1'b0));
							else
								put(CMD_TEXT, gen_pat[j]);
						end
						if ($urandom_range(0, 5) == 0)
							put(CMD_TEXT, pick_sym(1'b0));
					end else begin
						repeat ($urandom_range(0, 10)) put(CMD_TEXT, pick_sym(1'b0));
					end
					put(CMD_END, 8'($urandom_range(0, 255)));
				end
			end else begin
				repeat ($urandom_range(1, 8))
					put(cmd_t'(2'($urandom_range(0, 3))), 8'($urandom_range(0, 255)));
			end
			if (seq % 10 == 9) begin
				pw = '0;
				pw.drain = 1'b1;
				pending.push_back(pw);
			end
			seq++;
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (pending.size() != 0 || in_valid || results_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (errors == 0 && results_due.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== wildcard_glob_matcher.f =====
hw/rtl/wgm_pkg.sv
hw/rtl/wgm_nfa.sv
hw/rtl/wildcard_glob_matcher.sv
tb/wildcard_glob_matcher_tb.sv
